// File: rtl/core/wtws_pkg.sv
package wtws_pkg;

   // Trigger layout, fixed by the transaction fields
   localparam int TRIGGER_COUNT = 25;
   localparam int LANE_COUNT    = 5;
   localparam int LANE_TRIGGERS = 5;
   localparam int WEIGHT_W      = 2;
   localparam int LANE_SUM_W    = 4;

   // Score and window sum widths
   localparam int SCORE_W = 7;
   localparam int SUM_W   = 15;

   // Register widths
   localparam int WEIGHTS_W   = 2 * TRIGGER_COUNT;
   localparam int ENTRY_THR_W = 7;
   localparam int WIN_LEN_W   = 8;
   localparam int WIN_THR_W   = 8;
   localparam int CSR_DATA_W  = WEIGHTS_W;
   localparam int CSR_INDEX_W = 3;

   // Register reset values
   localparam logic [WEIGHTS_W-1:0]   WEIGHTS_RESET   = '0;
   localparam logic                   MODE_RESET      = 1'b0;
   localparam logic [ENTRY_THR_W-1:0] ENTRY_THR_RESET = 7'd5;
   localparam logic [WIN_LEN_W-1:0]   WIN_LEN_RESET   = 8'd5;
   localparam logic [WIN_THR_W-1:0]   WIN_THR_RESET   = 8'd6;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_BULL_WEIGHTS       = 3'd0,
      REG_BEAR_WEIGHTS       = 3'd1,
      REG_SCORING_MODE       = 3'd2,
      REG_LONG_ENTRY_THR     = 3'd3,
      REG_SHORT_ENTRY_THR    = 3'd4,
      REG_WINDOW_LENGTH      = 3'd5,
      REG_LONG_WINDOW_THR    = 3'd6,
      REG_SHORT_WINDOW_THR   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [TRIGGER_COUNT-1:0] bull_active;
      logic [TRIGGER_COUNT-1:0] bear_active;
      logic                     revise_last;
   } req_data_type;

   typedef struct packed {
      logic               long_signal;
      logic               short_signal;
      logic               long_confluence;
      logic               short_confluence;
      logic [SCORE_W-1:0] bull_score;
      logic [SCORE_W-1:0] bear_score;
      logic [SUM_W-1:0]   bull_window_sum;
      logic [SUM_W-1:0]   bear_window_sum;
   } rsp_data_type;

   typedef struct packed {
      logic [LANE_SUM_W-1:0] bull;
      logic [LANE_SUM_W-1:0] bear;
   } lane_sum_type;

   typedef struct packed {
      logic [SCORE_W-1:0] bull;
      logic [SCORE_W-1:0] bear;
   } score_pair_type;

   typedef struct packed {
      logic [SUM_W-1:0] bull;
      logic [SUM_W-1:0] bear;
   } sum_pair_type;

   typedef struct packed {
      score_pair_type score;
      sum_pair_type   window_sum;
   } window_result_type;

endpackage

// File: rtl/core/weighted_trigger_window_scorer.sv
// Stages: score merge (A), ring update and read (B), compare into the output
// register, which drives rsp_valid. Throughput: one transaction per cycle
// unless rsp_stall holds the output; the prefix-sum ring takes one write and
// one read per cycle, so the window length does not change the rate.
// Reset clears the pipeline, bar count, ring pointer and running sums and
// loads the register reset values; the ring itself is not swept.
module weighted_trigger_window_scorer #(
   parameter int HISTORY_DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  wtws_pkg::req_data_type                 req_data,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output wtws_pkg::rsp_data_type                 rsp_data,

   input  logic                                   csr_write_en,
   input  logic [wtws_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [wtws_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [wtws_pkg::WEIGHTS_W-1:0]   bull_weights_ff;
   logic [wtws_pkg::WEIGHTS_W-1:0]   bear_weights_ff;
   logic                             scoring_mode_ff;
   logic [wtws_pkg::ENTRY_THR_W-1:0] long_entry_thr_ff;
   logic [wtws_pkg::ENTRY_THR_W-1:0] short_entry_thr_ff;
   logic [wtws_pkg::WIN_LEN_W-1:0]   window_length_ff;
   logic [wtws_pkg::WIN_THR_W-1:0]   long_window_thr_ff;
   logic [wtws_pkg::WIN_THR_W-1:0]   short_window_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bull_weights_ff     <= wtws_pkg::WEIGHTS_RESET;
         bear_weights_ff     <= wtws_pkg::WEIGHTS_RESET;
         scoring_mode_ff     <= wtws_pkg::MODE_RESET;
         long_entry_thr_ff   <= wtws_pkg::ENTRY_THR_RESET;
         short_entry_thr_ff  <= wtws_pkg::ENTRY_THR_RESET;
         window_length_ff    <= wtws_pkg::WIN_LEN_RESET;
         long_window_thr_ff  <= wtws_pkg::WIN_THR_RESET;
         short_window_thr_ff <= wtws_pkg::WIN_THR_RESET;
      end else if (csr_write_en) begin
         unique case (wtws_pkg::csr_index_type'(csr_index))
            wtws_pkg::REG_BULL_WEIGHTS: begin
               bull_weights_ff <= csr_wdata[wtws_pkg::WEIGHTS_W-1:0];
            end
            wtws_pkg::REG_BEAR_WEIGHTS: begin
               bear_weights_ff <= csr_wdata[wtws_pkg::WEIGHTS_W-1:0];
            end
            wtws_pkg::REG_SCORING_MODE: begin
               scoring_mode_ff <= csr_wdata[0];
            end
            wtws_pkg::REG_LONG_ENTRY_THR: begin
               long_entry_thr_ff <= csr_wdata[wtws_pkg::ENTRY_THR_W-1:0];
            end
            wtws_pkg::REG_SHORT_ENTRY_THR: begin
               short_entry_thr_ff <= csr_wdata[wtws_pkg::ENTRY_THR_W-1:0];
            end
            wtws_pkg::REG_WINDOW_LENGTH: begin
               window_length_ff <= csr_wdata[wtws_pkg::WIN_LEN_W-1:0];
            end
            wtws_pkg::REG_LONG_WINDOW_THR: begin
               long_window_thr_ff <= csr_wdata[wtws_pkg::WIN_THR_W-1:0];
            end
            wtws_pkg::REG_SHORT_WINDOW_THR: begin
               short_window_thr_ff <= csr_wdata[wtws_pkg::WIN_THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control
   // A: merged scores, B: ring read data, then the output register.
   // Each stage advances when the stage after it is empty or advancing,
   // so bubbles fill up even while the output transaction is stalled.
   // ------------------------------------------------------------------
   logic stage_a_valid_ff;
   logic stage_b_valid_ff;
   logic rsp_valid_ff;
   logic adv_out;
   logic adv_b;
   logic adv_a;
   logic req_take;
   logic revise_a_ff;

   assign adv_out  = !rsp_valid_ff || !rsp_stall;
   assign adv_b    = !stage_b_valid_ff || adv_out;
   assign adv_a    = !stage_a_valid_ff || adv_b;
   assign req_take = req_valid && adv_a;

   assign req_stall = !adv_a;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_a_valid_ff <= 1'b0;
         stage_b_valid_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (adv_a) begin
            stage_a_valid_ff <= req_valid;
         end
         if (adv_b) begin
            stage_b_valid_ff <= stage_a_valid_ff;
         end
         if (adv_out) begin
            rsp_valid_ff <= stage_b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a) begin
         revise_a_ff <= req_data.revise_last;
      end
   end

   // ------------------------------------------------------------------
   // Scoring lanes: each lane weighs a group of triggers for both sides
   // ------------------------------------------------------------------
   localparam int LANE_W_BITS = wtws_pkg::WEIGHT_W * wtws_pkg::LANE_TRIGGERS;

   wtws_pkg::lane_sum_type   lane_sums [wtws_pkg::LANE_COUNT];
   wtws_pkg::score_pair_type score_a;

   for (genvar l = 0; l < wtws_pkg::LANE_COUNT; l++) begin : g_lane
      wtws_lane u_lane (
         .bull_flags   (req_data.bull_active[l*wtws_pkg::LANE_TRIGGERS +:
                                             wtws_pkg::LANE_TRIGGERS]),
         .bear_flags   (req_data.bear_active[l*wtws_pkg::LANE_TRIGGERS +:
                                             wtws_pkg::LANE_TRIGGERS]),
         .bull_weights (bull_weights_ff[l*LANE_W_BITS +: LANE_W_BITS]),
         .bear_weights (bear_weights_ff[l*LANE_W_BITS +: LANE_W_BITS]),
         .lane_sum     (lane_sums[l])
      );
   end

   // Merge the lane partials into the bar scores, registered as stage A
   wtws_merge u_merge (
      .clock     (clock),
      .load      (req_take),
      .lane_sums (lane_sums),
      .score     (score_a)
   );

   // ------------------------------------------------------------------
   // Window: advance the ring, update prefix sums, read the window start
   // ------------------------------------------------------------------
   wtws_pkg::window_result_type win_result;

   wtws_window #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .commit        (adv_b && stage_a_valid_ff),
      .load          (adv_b),
      .revise        (revise_a_ff),
      .score_a       (score_a),
      .window_length (window_length_ff),
      .result        (win_result)
   );

   // ------------------------------------------------------------------
   // Threshold compare into the output register
   // ------------------------------------------------------------------
   logic signed [wtws_pkg::SCORE_W+1:0] bar_diff;
   logic signed [wtws_pkg::SUM_W+1:0]   win_diff;
   wtws_pkg::rsp_data_type              rsp_data_in;
   wtws_pkg::rsp_data_type              rsp_data_ff;

   always_comb begin
      bar_diff = $signed({2'b00, win_result.score.bull})
               - $signed({2'b00, win_result.score.bear});
      win_diff = $signed({2'b00, win_result.window_sum.bull})
               - $signed({2'b00, win_result.window_sum.bear});

      rsp_data_in.bull_score      = win_result.score.bull;
      rsp_data_in.bear_score      = win_result.score.bear;
      rsp_data_in.bull_window_sum = win_result.window_sum.bull;
      rsp_data_in.bear_window_sum = win_result.window_sum.bear;

      if (!scoring_mode_ff) begin
         // Shared: compare bull minus bear against both signs
         rsp_data_in.long_signal  = bar_diff >= $signed({2'b00, long_entry_thr_ff});
         rsp_data_in.short_signal = bar_diff <= -$signed({2'b00, short_entry_thr_ff});
         rsp_data_in.long_confluence =
            win_diff >= $signed({9'd0, long_window_thr_ff});
         rsp_data_in.short_confluence =
            win_diff <= -$signed({9'd0, short_window_thr_ff});
      end else begin
         // Independent: each side against its own threshold
         rsp_data_in.long_signal  = win_result.score.bull >= long_entry_thr_ff;
         rsp_data_in.short_signal = win_result.score.bear >= short_entry_thr_ff;
         rsp_data_in.long_confluence =
            win_result.window_sum.bull >= wtws_pkg::SUM_W'(long_window_thr_ff);
         rsp_data_in.short_confluence =
            win_result.window_sum.bear >= wtws_pkg::SUM_W'(short_window_thr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // An accepted transaction always lands in stage A
   a_accept_fills_a: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> stage_a_valid_ff)
      else $error("accepted transaction lost before stage A");

   // A new result only appears behind a valid stage B
   a_rsp_from_b: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(stage_b_valid_ff))
      else $error("result raised without a transaction in stage B");

   // Independent mode: long signal agrees with the delivered bull score
   a_indep_long: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && scoring_mode_ff) |->
         (rsp_data_ff.long_signal == (rsp_data_ff.bull_score >= long_entry_thr_ff)))
      else $error("independent long signal disagrees with bull score");

endmodule

// File: rtl/core/wtws_lane.sv
module wtws_lane (
   input  logic [wtws_pkg::LANE_TRIGGERS-1:0]                     bull_flags,
   input  logic [wtws_pkg::LANE_TRIGGERS-1:0]                     bear_flags,
   input  logic [wtws_pkg::WEIGHT_W*wtws_pkg::LANE_TRIGGERS-1:0]  bull_weights,
   input  logic [wtws_pkg::WEIGHT_W*wtws_pkg::LANE_TRIGGERS-1:0]  bear_weights,
   output wtws_pkg::lane_sum_type                                 lane_sum
);

   logic [wtws_pkg::LANE_SUM_W-1:0] bull_acc;
   logic [wtws_pkg::LANE_SUM_W-1:0] bear_acc;

   // Add the weights of the active triggers of this lane
   always_comb begin
      bull_acc = '0;
      bear_acc = '0;
      for (int n = 0; n < wtws_pkg::LANE_TRIGGERS; n++) begin
         if (bull_flags[n]) begin
            bull_acc = bull_acc + wtws_pkg::LANE_SUM_W'(
               bull_weights[wtws_pkg::WEIGHT_W*n +: wtws_pkg::WEIGHT_W]);
         end
         if (bear_flags[n]) begin
            bear_acc = bear_acc + wtws_pkg::LANE_SUM_W'(
               bear_weights[wtws_pkg::WEIGHT_W*n +: wtws_pkg::WEIGHT_W]);
         end
      end
   end

   assign lane_sum.bull = bull_acc;
   assign lane_sum.bear = bear_acc;

endmodule

// File: rtl/core/wtws_merge.sv
module wtws_merge (
   input  logic                            clock,
   input  logic                            load,
   input  wtws_pkg::lane_sum_type          lane_sums [wtws_pkg::LANE_COUNT],
   output wtws_pkg::score_pair_type        score
);

   wtws_pkg::score_pair_type score_in;
   wtws_pkg::score_pair_type score_ff;

   // Combine the lane partial sums into the bar scores
   always_comb begin
      score_in = '0;
      for (int l = 0; l < wtws_pkg::LANE_COUNT; l++) begin
         score_in.bull = score_in.bull + wtws_pkg::SCORE_W'(lane_sums[l].bull);
         score_in.bear = score_in.bear + wtws_pkg::SCORE_W'(lane_sums[l].bear);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         score_ff <= score_in;
      end
   end

   assign score = score_ff;

endmodule

// File: rtl/core/wtws_window.sv
module wtws_window #(
   parameter int HISTORY_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                commit,
   input  logic                                load,
   input  logic                                revise,
   input  wtws_pkg::score_pair_type            score_a,
   input  logic [wtws_pkg::WIN_LEN_W-1:0]      window_length,
   output wtws_pkg::window_result_type         result
);

   localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 2);
   localparam int ADDR_W = $clog2(2 * HISTORY_DEPTH + 1);

   typedef enum logic [1:0] {
      SUB_ZERO,
      SUB_PREV,
      SUB_RING
   } sub_sel_type;

   // Ring of exclusive prefix sums: entry of a bar holds the cumulative
   // score of all bars before it
   wtws_pkg::sum_pair_type ring_mem [HISTORY_DEPTH];

   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   wtws_pkg::sum_pair_type cum_prev_ff, cum_prev_in;
   wtws_pkg::sum_pair_type cum_new_ff, cum_new_in;

   logic                   first_bar;
   logic                   new_bar;
   logic                   step_slot;
   logic [CNT_W-1:0]       win_len;
   logic [ADDR_W-1:0]      addr_wide;
   logic [SLOT_W-1:0]      rd_addr;
   sub_sel_type            sub_sel_in;

   wtws_pkg::sum_pair_type   ring_rd_ff;
   wtws_pkg::sum_pair_type   cum_new_b_ff;
   wtws_pkg::sum_pair_type   cum_prev_b_ff;
   wtws_pkg::score_pair_type score_b_ff;
   sub_sel_type              sub_sel_ff;
   wtws_pkg::sum_pair_type   sub_val;

   always_comb begin
      first_bar = (count_ff == '0);
      new_bar   = !revise || first_bar;
      step_slot = !revise && !first_bar;

      if (!step_slot) begin
         slot_in = slot_ff;
      end else if (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) begin
         slot_in = '0;
      end else begin
         slot_in = slot_ff + SLOT_W'(1);
      end

      if (new_bar && (count_ff != CNT_W'(HISTORY_DEPTH + 1))) begin
         count_in = count_ff + CNT_W'(1);
      end else begin
         count_in = count_ff;
      end

      cum_prev_in     = new_bar ? cum_new_ff : cum_prev_ff;
      cum_new_in.bull = cum_prev_in.bull + wtws_pkg::SUM_W'(score_a.bull);
      cum_new_in.bear = cum_prev_in.bear + wtws_pkg::SUM_W'(score_a.bear);

      // Clamp the window to one bar at least and the ring depth at most
      if (window_length == '0) begin
         win_len = CNT_W'(1);
      end else if (int'(window_length) > HISTORY_DEPTH) begin
         win_len = CNT_W'(HISTORY_DEPTH);
      end else begin
         win_len = CNT_W'(window_length);
      end

      // Oldest bar in the window sits len-1 slots behind the newest
      addr_wide = ADDR_W'(slot_in) + ADDR_W'(HISTORY_DEPTH + 1) - ADDR_W'(win_len);
      if (addr_wide >= ADDR_W'(HISTORY_DEPTH)) begin
         addr_wide = addr_wide - ADDR_W'(HISTORY_DEPTH);
      end
      rd_addr = (win_len == CNT_W'(1)) ? slot_in : SLOT_W'(addr_wide);

      // Window reaching before the first bar subtracts nothing
      if (count_in <= win_len) begin
         sub_sel_in = SUB_ZERO;
      end else if (win_len == CNT_W'(1)) begin
         sub_sel_in = SUB_PREV;
      end else begin
         sub_sel_in = SUB_RING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= '0;
         count_ff    <= '0;
         cum_prev_ff <= '0;
         cum_new_ff  <= '0;
      end else if (commit) begin
         slot_ff     <= slot_in;
         count_ff    <= count_in;
         cum_prev_ff <= cum_prev_in;
         cum_new_ff  <= cum_new_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && new_bar) begin
         ring_mem[slot_in] <= cum_prev_in;
      end
      if (load) begin
         ring_rd_ff <= ring_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cum_new_b_ff  <= cum_new_in;
         cum_prev_b_ff <= cum_prev_in;
         score_b_ff    <= score_a;
         sub_sel_ff    <= sub_sel_in;
      end
   end

   always_comb begin
      unique case (sub_sel_ff)
         SUB_ZERO: sub_val = '0;
         SUB_PREV: sub_val = cum_prev_b_ff;
         SUB_RING: sub_val = ring_rd_ff;
         default:  sub_val = '0;
      endcase
   end

   assign result.score           = score_b_ff;
   assign result.window_sum.bull = cum_new_b_ff.bull - sub_val.bull;
   assign result.window_sum.bear = cum_new_b_ff.bear - sub_val.bear;

endmodule

// File: tb/tb_weighted_trigger_window_scorer.sv
`timescale 1ns / 100ps

module tb_weighted_trigger_window_scorer;
   import wtws_pkg::*;

   localparam int          CLOCK_PERIOD = 10;
   localparam int          CYCLE_LIMIT  = 500000;
   localparam int          RING_SLOTS   = 256;
   localparam int          PHASE_BARS   = 250;
   localparam int          PHASE_COUNT  = 7;
   localparam int          SETTLE_CYCLES = 8;
   localparam logic        MODE_SHARED      = 1'b0;
   localparam logic        MODE_INDEPENDENT = 1'b1;
   localparam logic [TRIGGER_COUNT-1:0] ALL_FLAGS = '1;
   localparam logic [WEIGHTS_W-1:0]     WEIGHTS_ALL_THREE = '1;
   localparam logic [WEIGHTS_W-1:0]     WEIGHTS_ALL_ONE   = 50'h1555555555555;
   localparam logic [WEIGHTS_W-1:0]     WEIGHTS_ALL_TWO   = 50'h2AAAAAAAAAAAA;

   // Shadow copy of the register file, written as one set while the block is idle
   typedef struct {
      logic [WEIGHTS_W-1:0]   bull_weights;
      logic [WEIGHTS_W-1:0]   bear_weights;
      logic                   scoring_mode;
      logic [ENTRY_THR_W-1:0] long_entry_thr;
      logic [ENTRY_THR_W-1:0] short_entry_thr;
      logic [WIN_LEN_W-1:0]   window_length;
      logic [WIN_THR_W-1:0]   long_window_thr;
      logic [WIN_THR_W-1:0]   short_window_thr;
   } scorer_settings_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_data_type             req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_data_type             rsp_data;
   logic                     csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   // Predictor state: score ring, newest bar pointer and the active settings
   scorer_settings_t         settings;
   logic [SCORE_W-1:0]       bull_ring [RING_SLOTS];
   logic [SCORE_W-1:0]       bear_ring [RING_SLOTS];
   logic [7:0]               newest_bar;
   logic                     any_bar_taken;

   rsp_data_type             pending_scores [$];
   int                       failures = 0;
   int                       cycle_count = 0;
   logic                     req_gaps_on = 1'b1;
   logic                     rsp_gaps_on = 1'b1;

   weighted_trigger_window_scorer uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver back-pressure: random stall bursts while rsp_gaps_on is set
   always @(posedge clock) begin
      static int stall_left = 0;
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_gaps_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 10) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Sum the 2-bit weights of the flagged triggers of one side
   function automatic logic [SCORE_W-1:0] weighted_points(logic [WEIGHTS_W-1:0] weights,
                                                          logic [TRIGGER_COUNT-1:0] flags);
      logic [SCORE_W-1:0] points;
      points = '0;
      for (int n = 0; n < TRIGGER_COUNT; n++) begin
         if (flags[n]) begin
            points = points + SCORE_W'(weights[2*n +: 2]);
         end
      end
      return points;
   endfunction

   // Take one accepted bar into the ring and work out its scores and window sums
   function automatic rsp_data_type score_bar(req_data_type bar);
      rsp_data_type       result;
      logic [SCORE_W-1:0] bull;
      logic [SCORE_W-1:0] bear;
      logic [SUM_W-1:0]   bull_sum;
      logic [SUM_W-1:0]   bear_sum;
      logic [7:0]         slot;
      int                 span;
      int                 bar_net;
      int                 window_net;

      bull = weighted_points(settings.bull_weights, bar.bull_active);
      bear = weighted_points(settings.bear_weights, bar.bear_active);

      // A revise before any bar behaves like the first new bar: stay on slot 0
      if (!bar.revise_last && any_bar_taken) begin
         newest_bar = newest_bar + 8'd1;
      end
      any_bar_taken = 1'b1;
      bull_ring[newest_bar] = bull;
      bear_ring[newest_bar] = bear;

      // A zero window length still covers the current bar
      span = (settings.window_length == 0) ? 1 : int'(settings.window_length);
      if (span > RING_SLOTS) begin
         span = RING_SLOTS;
      end
      bull_sum = '0;
      bear_sum = '0;
      for (int k = 0; k < span; k++) begin
         slot = newest_bar - 8'(k);
         bull_sum = bull_sum + SUM_W'(bull_ring[slot]);
         bear_sum = bear_sum + SUM_W'(bear_ring[slot]);
      end

      if (settings.scoring_mode == MODE_SHARED) begin
         bar_net    = int'(bull) - int'(bear);
         window_net = int'(bull_sum) - int'(bear_sum);
         result.long_signal      = bar_net >= int'(settings.long_entry_thr);
         result.short_signal     = bar_net <= -int'(settings.short_entry_thr);
         result.long_confluence  = window_net >= int'(settings.long_window_thr);
         result.short_confluence = window_net <= -int'(settings.short_window_thr);
      end else begin
         result.long_signal      = bull >= SCORE_W'(settings.long_entry_thr);
         result.short_signal     = bear >= SCORE_W'(settings.short_entry_thr);
         result.long_confluence  = bull_sum >= SUM_W'(settings.long_window_thr);
         result.short_confluence = bear_sum >= SUM_W'(settings.short_window_thr);
      end
      result.bull_score      = bull;
      result.bear_score      = bear;
      result.bull_window_sum = bull_sum;
      result.bear_window_sum = bear_sum;
      return result;
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         failures++;
      end
   endtask

   // Compare every accepted result against the oldest pending prediction
   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_scores.size() == 0) begin
            $error("unexpected result transaction: %h", rsp_data);
            failures++;
         end else begin
            want = pending_scores.pop_front();
            check_field("long_signal", want.long_signal, rsp_data.long_signal);
            check_field("short_signal", want.short_signal, rsp_data.short_signal);
            check_field("long_confluence", want.long_confluence, rsp_data.long_confluence);
            check_field("short_confluence", want.short_confluence,
                        rsp_data.short_confluence);
            check_field("bull_score", want.bull_score, rsp_data.bull_score);
            check_field("bear_score", want.bear_score, rsp_data.bear_score);
            check_field("bull_window_sum", want.bull_window_sum, rsp_data.bull_window_sum);
            check_field("bear_window_sum", want.bear_window_sum, rsp_data.bear_window_sum);
         end
      end
   end

   // Hold one bar on the request channel until it is taken, then predict it
   task automatic send_bar(input logic [TRIGGER_COUNT-1:0] bull_flags,
                           input logic [TRIGGER_COUNT-1:0] bear_flags,
                           input logic revise);
      req_data_type bar;
      bar.bull_active = bull_flags;
      bar.bear_active = bear_flags;
      bar.revise_last = revise;
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= bar;
      do @(posedge clock); while (req_stall);
      pending_scores.push_back(score_bar(bar));
   endtask

   // Drop valid, wait out every pending result plus the pipeline depth
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input csr_index_type index, input logic [CSR_DATA_W-1:0] value);
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write the full register set; call only while the block is idle
   task automatic apply_settings(input scorer_settings_t next);
      csr_write_en <= 1'b1;
      put_reg(REG_BULL_WEIGHTS, next.bull_weights);
      put_reg(REG_BEAR_WEIGHTS, next.bear_weights);
      put_reg(REG_SCORING_MODE, CSR_DATA_W'(next.scoring_mode));
      put_reg(REG_LONG_ENTRY_THR, CSR_DATA_W'(next.long_entry_thr));
      put_reg(REG_SHORT_ENTRY_THR, CSR_DATA_W'(next.short_entry_thr));
      put_reg(REG_WINDOW_LENGTH, CSR_DATA_W'(next.window_length));
      put_reg(REG_LONG_WINDOW_THR, CSR_DATA_W'(next.long_window_thr));
      put_reg(REG_SHORT_WINDOW_THR, CSR_DATA_W'(next.short_window_thr));
      csr_write_en <= 1'b0;
      settings = next;
      @(posedge clock);
   endtask

   function automatic logic [WEIGHTS_W-1:0] random_weights;
      case ($urandom_range(0, 7))
         0:       return WEIGHTS_ALL_THREE;
         1:       return WEIGHTS_W'({$urandom, $urandom}) & WEIGHTS_W'({$urandom, $urandom});
         2:       return WEIGHTS_ALL_TWO;
         default: return WEIGHTS_W'({$urandom, $urandom});
      endcase
   endfunction

   function automatic scorer_settings_t random_settings;
      scorer_settings_t s;
      s.bull_weights    = random_weights();
      s.bear_weights    = random_weights();
      s.scoring_mode    = $urandom_range(0, 1) ? MODE_INDEPENDENT : MODE_SHARED;
      s.long_entry_thr  = ($urandom_range(0, 9) == 0) ? ENTRY_THR_W'($urandom)
                                                      : ENTRY_THR_W'($urandom_range(1, 40));
      s.short_entry_thr = ($urandom_range(0, 9) == 0) ? ENTRY_THR_W'($urandom)
                                                      : ENTRY_THR_W'($urandom_range(1, 40));
      // Mostly short windows; now and then zero, 200 and the 8-bit top
      case ($urandom_range(0, 9))
         0:       s.window_length = 8'd0;
         1:       s.window_length = 8'd200;
         2:       s.window_length = 8'd255;
         default: s.window_length = WIN_LEN_W'($urandom_range(1, 16));
      endcase
      if (s.scoring_mode == MODE_SHARED) begin
         s.long_window_thr  = WIN_THR_W'($urandom_range(0, 60));
         s.short_window_thr = WIN_THR_W'($urandom_range(0, 60));
      end else begin
         s.long_window_thr  = WIN_THR_W'($urandom_range(0, 255));
         s.short_window_thr = WIN_THR_W'($urandom_range(0, 255));
      end
      return s;
   endfunction

   function automatic logic [TRIGGER_COUNT-1:0] random_flags;
      case ($urandom_range(0, 5))
         0:       return TRIGGER_COUNT'($urandom) & TRIGGER_COUNT'($urandom);
         1:       return TRIGGER_COUNT'($urandom) | TRIGGER_COUNT'($urandom);
         2:       return TRIGGER_COUNT'(1) << $urandom_range(0, TRIGGER_COUNT - 1);
         default: return TRIGGER_COUNT'($urandom);
      endcase
   endfunction

   // The very first transactions after reset are revisions: they must land in slot 0
   task automatic test_revise_before_first_bar;
      scorer_settings_t s;
      s = '{WEIGHTS_ALL_THREE, WEIGHTS_ALL_ONE, MODE_SHARED, 7'd5, 7'd5, 8'd5, 8'd6, 8'd6};
      apply_settings(s);
      send_bar(ALL_FLAGS, '0, 1'b1);
      send_bar(TRIGGER_COUNT'(1), TRIGGER_COUNT'(1) << (TRIGGER_COUNT - 1), 1'b1);
      send_bar('0, '0, 1'b0);
   endtask

   // Empty, full and single-trigger flag words, plus a revision of the newest bar
   task automatic test_flag_extremes;
      send_bar(ALL_FLAGS, ALL_FLAGS, 1'b0);
      send_bar(ALL_FLAGS, '0, 1'b0);
      send_bar('0, ALL_FLAGS, 1'b0);
      send_bar(TRIGGER_COUNT'(1) << (TRIGGER_COUNT - 1), TRIGGER_COUNT'(1), 1'b0);
      send_bar(25'h0AAAAAA, 25'h1555555, 1'b1);
   endtask

   // Zero thresholds fire at least one side; zero window length sums just this bar; then top thresholds
   task automatic test_threshold_extremes;
      scorer_settings_t s;
      drain();
      s = '{WEIGHTS_ALL_TWO, WEIGHTS_ALL_THREE, MODE_SHARED, '0, '0, '0, '0, '0};
      apply_settings(s);
      send_bar('0, '0, 1'b0);
      send_bar(ALL_FLAGS, 25'h00000FF, 1'b0);
      send_bar(25'h000000F, ALL_FLAGS, 1'b0);
      drain();
      s = '{WEIGHTS_ALL_THREE, WEIGHTS_ALL_THREE, MODE_SHARED, '1, '1, 8'd1, '1, '1};
      apply_settings(s);
      send_bar(ALL_FLAGS, '0, 1'b0);
      send_bar('0, ALL_FLAGS, 1'b0);
   endtask

   // Independent pools with the largest scores and the longest 8-bit window
   task automatic test_independent_mode;
      scorer_settings_t s;
      drain();
      s = '{WEIGHTS_ALL_THREE, WEIGHTS_ALL_THREE, MODE_INDEPENDENT, 7'd75, 7'd75,
            8'd255, 8'd225, 8'd225};
      apply_settings(s);
      send_bar(ALL_FLAGS, ALL_FLAGS, 1'b0);
      send_bar('0, '0, 1'b1);
      send_bar(ALL_FLAGS, '0, 1'b0);
      send_bar('0, ALL_FLAGS, 1'b0);
   endtask

   // Random settings per phase; enough bars to wrap the ring several times
   task automatic test_random_phases;
      logic revise;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain();
         // Hold the last phase free of gaps; phases 3 and 4 each drop the gaps on one side
         req_gaps_on = (phase != PHASE_COUNT - 1) && (phase != 3);
         rsp_gaps_on = (phase != PHASE_COUNT - 1) && (phase != 4);
         apply_settings(random_settings());
         for (int n = 0; n < PHASE_BARS; n++) begin
            revise = ($urandom_range(0, 4) == 0);
            send_bar(random_flags(), random_flags(), revise);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < RING_SLOTS; i++) begin
         bull_ring[i] = '0;
         bear_ring[i] = '0;
      end
      newest_bar    = '0;
      any_bar_taken = 1'b0;
      settings = '{WEIGHTS_RESET, WEIGHTS_RESET, MODE_RESET, ENTRY_THR_RESET, ENTRY_THR_RESET,
                   WIN_LEN_RESET, WIN_THR_RESET, WIN_THR_RESET};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_revise_before_first_bar();
      test_flag_extremes();
      test_threshold_extremes();
      test_independent_mode();
      test_random_phases();

      drain();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
